/* rtl/spfd_pkg.sv */
// shared types and constants for the single precision float divider
`default_nettype none
package spfd_pkg;
   localparam int unsigned MantWidth = 24;
   localparam int unsigned QuoWidth  = 25;
   localparam logic [7:0]  ExpBias   = 8'd127;
   localparam logic [31:0] PosInf    = 32'h7F80_0000;

   typedef enum logic [2:0] {
      STATUS_NORMAL        = 3'd0,
      STATUS_ZERO_DIVIDEND = 3'd1,
      STATUS_DIV_ZERO      = 3'd2,
      STATUS_UNDERFLOW     = 3'd3,
      STATUS_OVERFLOW      = 3'd4
   } status_type;

   // everything except the partial remainder and quotient travels alongside
   typedef struct packed {
      logic             valid;
      logic             sign;
      logic signed [9:0] exp_diff;
      logic [2:0]       special;
      logic [MantWidth-1:0] divisor;
   } ctrl_type;
endpackage
`default_nettype wire

/* rtl/spfd_cell.sv */
// one restoring division cell: produces one quotient bit per stage
`default_nettype none
module spfd_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire spfd_pkg::ctrl_type      ctrl_in,
   input  wire logic [24:0]             rem_in,
   input  wire logic [24:0]             quo_in,
   output spfd_pkg::ctrl_type           ctrl_out,
   output logic [24:0]                  rem_out,
   output logic [24:0]                  quo_out
);
   import spfd_pkg::*;

   ctrl_type    ctrl_ff;
   logic [24:0] rem_ff, rem_in_next;
   logic [24:0] quo_ff, quo_in_next;
   logic [25:0] trial;
   logic        bit_q;

   // remainder stays below twice the divisor, so 25 bits suffice
   always_comb begin
      trial       = {1'b0, rem_in} - {2'b00, ctrl_in.divisor};
      bit_q       = !trial[25];
      rem_in_next = bit_q ? {trial[23:0], 1'b0} : {rem_in[23:0], 1'b0};
      quo_in_next = {quo_in[23:0], bit_q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      if (advance) begin
         ctrl_ff.sign     <= ctrl_in.sign;
         ctrl_ff.exp_diff <= ctrl_in.exp_diff;
         ctrl_ff.special  <= ctrl_in.special;
         ctrl_ff.divisor  <= ctrl_in.divisor;
         rem_ff           <= rem_in_next;
         quo_ff           <= quo_in_next;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
endmodule
`default_nettype wire

/* rtl/single_precision_float_divider.sv */
// top level: pipelined truncating single precision divider
// Usage: present dividend and divisor bit patterns on req_* with req_valid; the
// quotient pattern and status come back on rsp_* with rsp_valid.
// The significand division is a row of 25 restoring cells, one quotient bit
// each, followed by one output register: the first cell loads at the accepting
// edge, and rsp_valid rises once the last cell's result is in the output register.
// One transaction per cycle unless stalled; the whole row advances together.
// When the receiver stalls (rsp_valid high, rsp_ready low) the row holds and
// req_ready drops; bubbles in the row are not compressed, and req_ready is
// high whenever the output register is empty or being drained.
// Synchronous reset empties all stages; no transaction is lost or invented.
// Zero operands, underflow and overflow are flagged on rsp_status.
`default_nettype none
module single_precision_float_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_dividend_bits,
   input  wire logic [31:0] req_divisor_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_quotient_bits,
   output logic [2:0]       rsp_status
);
   import spfd_pkg::*;

   localparam int unsigned Stages = QuoWidth;

   ctrl_type    ctrl  [Stages+1];
   logic [24:0] rem   [Stages+1];
   logic [24:0] quo   [Stages+1];
   logic        advance;
   logic        out_valid_ff;
   logic [31:0] out_q_ff;
   logic [2:0]  out_st_ff;
   logic [31:0] q_in;
   logic [2:0]  st_in;
   logic signed [9:0] exp_z;
   ctrl_type    last;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      ctrl[0].valid    = req_valid;
      ctrl[0].sign     = req_dividend_bits[31] ^ req_divisor_bits[31];
      ctrl[0].exp_diff = $signed({2'b00, req_dividend_bits[30:23]})
                       - $signed({2'b00, req_divisor_bits[30:23]});
      ctrl[0].divisor  = {1'b1, req_divisor_bits[22:0]};
      if (req_dividend_bits[30:0] == 31'd0) begin
         ctrl[0].special = STATUS_ZERO_DIVIDEND;
      end else if (req_divisor_bits[30:0] == 31'd0) begin
         ctrl[0].special = STATUS_DIV_ZERO;
      end else begin
         ctrl[0].special = STATUS_NORMAL;
      end
      rem[0] = {1'b0, 1'b1, req_dividend_bits[22:0]};
      quo[0] = '0;
   end

   for (genvar i = 0; i < Stages; i++) begin : g_cell
      spfd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctrl_in  (ctrl[i]),
         .rem_in   (rem[i]),
         .quo_in   (quo[i]),
         .ctrl_out (ctrl[i+1]),
         .rem_out  (rem[i+1]),
         .quo_out  (quo[i+1])
      );
   end

   assign last = ctrl[Stages];

   always_comb begin
      exp_z = last.exp_diff + $signed({2'b00, ExpBias});
      if (!quo[Stages][24]) begin
         exp_z = exp_z - 10'sd1;
      end
      q_in  = {last.sign, exp_z[7:0],
               quo[Stages][24] ? quo[Stages][23:1] : quo[Stages][22:0]};
      st_in = STATUS_NORMAL;
      priority if (last.special == STATUS_ZERO_DIVIDEND) begin
         q_in  = '0;
         st_in = STATUS_ZERO_DIVIDEND;
      end else if (last.special == STATUS_DIV_ZERO) begin
         q_in  = PosInf;
         st_in = STATUS_DIV_ZERO;
      end else if (exp_z <= 10'sd0) begin
         q_in  = '0;
         st_in = STATUS_UNDERFLOW;
      end else if (exp_z >= 10'sd255) begin
         q_in  = PosInf;
         st_in = STATUS_OVERFLOW;
      end else begin
         st_in = STATUS_NORMAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
      end
      if (advance) begin
         out_q_ff  <= q_in;
         out_st_ff <= st_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_quotient_bits = out_q_ff;
   assign rsp_status        = out_st_ff;
endmodule
`default_nettype wire

/* bench/single_precision_float_divider_test.sv */
// self-checking testbench for the pipelined truncating single precision divider
`default_nettype none
module single_precision_float_divider_test;
   timeunit 1ns;
   timeprecision 1ps;
   import spfd_pkg::*;

   typedef struct {
      logic [31:0] quotient;
      status_type  status;
   } quotient_type;

   typedef struct {
      logic [31:0] dividend;
      logic [31:0] divisor;
      logic        known;
      logic [31:0] quotient;
      status_type  status;
   } stimulus_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_dividend_bits = '0;
   logic [31:0] req_divisor_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_quotient_bits;
   logic [2:0]  rsp_status;

   quotient_type     pending_quotients[$];
   stimulus_row_type directed_rows[$];
   int unsigned      mismatch_count = 0;
   int unsigned      quotients_checked = 0;
   int unsigned      operand_pairs_sent = 0;
   int unsigned      stall_left = 0;
   bit               quiet_tail = 1'b0;

   always #4 clock = ~clock;

   single_precision_float_divider dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_dividend_bits(req_dividend_bits),
      .req_divisor_bits(req_divisor_bits),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_quotient_bits(rsp_quotient_bits),
      .rsp_status(rsp_status)
   );

   function automatic quotient_type divide_patterns(logic [31:0] a, logic [31:0] b);
      quotient_type      r;
      logic [23:0]       sig_a;
      logic [23:0]       sig_b;
      logic [47:0]       q;
      logic [23:0]       mant;
      int                biased_exp;
      if (a[30:0] == '0) begin
         r.quotient = '0;
         r.status   = STATUS_ZERO_DIVIDEND;
         return r;
      end
      if (b[30:0] == '0) begin
         r.quotient = PosInf;
         r.status   = STATUS_DIV_ZERO;
         return r;
      end
      biased_exp = int'(a[30:23]) - int'(b[30:23]) + 127;
      sig_a = {1'b1, a[22:0]};
      sig_b = {1'b1, b[22:0]};
      q = {sig_a, 24'd0} / {24'd0, sig_b};
      if (q[24]) begin
         mant = q[24:1];
      end else begin
         mant = q[23:0];
         biased_exp = biased_exp - 1;
      end
      if (biased_exp <= 0) begin
         r.quotient = '0;
         r.status   = STATUS_UNDERFLOW;
      end else if (biased_exp >= 255) begin
         r.quotient = PosInf;
         r.status   = STATUS_OVERFLOW;
      end else begin
         r.quotient = {a[31] ^ b[31], biased_exp[7:0], mant[22:0]};
         r.status   = STATUS_NORMAL;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("mismatch %0t: %s got %h expected %h", $realtime, what, got, want);
   endtask

   task automatic add_row(logic [31:0] a, logic [31:0] b, logic known = 1'b0,
                          logic [31:0] q = '0, status_type st = STATUS_NORMAL);
      stimulus_row_type row;
      row.dividend = a;
      row.divisor  = b;
      row.known    = known;
      row.quotient = q;
      row.status   = st;
      directed_rows.push_back(row);
   endtask

   // one transaction; expectation taken from the table when typed in
   task automatic send_pair(logic [31:0] a, logic [31:0] b, logic known,
                            logic [31:0] q, status_type st);
      quotient_type expected;
      int           gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected = divide_patterns(a, b);
      if (known) begin
         expected.quotient = q;
         expected.status   = st;
      end
      req_valid         <= 1'b1;
      req_dividend_bits <= a;
      req_divisor_bits  <= b;
      do @(posedge clock); while (!req_ready);
      pending_quotients.push_back(expected);
      operand_pairs_sent++;
   endtask

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 7))
         0: v[30:0] = '0;
         1: v[30:23] = 8'hFF;
         2: v[30:23] = 8'h00;
         3: v[30:23] = 8'(127 + $urandom_range(0, 40) - 20);
         default: ;
      endcase
      return v;
   endfunction

   // receiver: stall bursts, checks each transaction against the oldest expectation
   always @(posedge clock) begin
      quotient_type expected;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_quotients.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_quotient_bits, '0);
            end else begin
               expected = pending_quotients.pop_front();
               quotients_checked++;
               if (rsp_quotient_bits !== expected.quotient)
                  report_mismatch("quotient", rsp_quotient_bits, expected.quotient);
               if (rsp_status !== expected.status)
                  report_mismatch("status", {29'd0, rsp_status}, {29'd0, expected.status});
            end
         end
         if (quiet_tail) begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 1) begin
            stall_left--;
         end else if (stall_left == 1) begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] a;
      logic [31:0] b;
      add_row(32'h0000_0000, 32'h3F80_0000, 1'b1, 32'h0, STATUS_ZERO_DIVIDEND);
      add_row(32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0, STATUS_ZERO_DIVIDEND);
      add_row(32'h3F80_0000, 32'h0000_0000, 1'b1, PosInf, STATUS_DIV_ZERO);
      add_row(32'hC000_0000, 32'h8000_0000, 1'b1, PosInf, STATUS_DIV_ZERO);
      add_row(32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h3F80_0000, STATUS_NORMAL);
      add_row(32'hC080_0000, 32'h4000_0000, 1'b1, 32'hC000_0000, STATUS_NORMAL);
      add_row(32'h0080_0000, 32'h7F00_0000, 1'b1, 32'h0, STATUS_UNDERFLOW);
      add_row(32'h8000_0001, 32'h7F80_0000, 1'b1, 32'h0, STATUS_UNDERFLOW);
      add_row(32'h7F00_0000, 32'h0080_0000, 1'b1, PosInf, STATUS_OVERFLOW);
      add_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b1, PosInf, STATUS_OVERFLOW);
      add_row(32'h3F80_0000, 32'h4040_0000);   // one third, truncated
      add_row(32'h3FFF_FFFF, 32'h3F80_0001);
      add_row(32'h3F80_0000, 32'h3FFF_FFFF);   // dividend significand below divisor
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // nan patterns divided as numbers
      add_row(32'h7F80_0000, 32'hFF80_0000);
      add_row(32'h007F_FFFF, 32'h0000_0001);   // denormals get the implicit one
      add_row(32'h4000_0000, 32'h3F80_0001);   // exponent edge near 1
      add_row(32'h0100_0000, 32'h3F80_0000);
      add_row(32'h0080_0000, 32'h3F80_0001);
      add_row(32'h7F7F_FFFF, 32'h3F80_0000);
      add_row(32'h7F7F_FFFF, 32'h3F7F_FFFF);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_pair(directed_rows[i].dividend, directed_rows[i].divisor,
                   directed_rows[i].known, directed_rows[i].quotient,
                   directed_rows[i].status);
      for (int n = 0; n < 1330; n++) begin
         if (n == 1100) quiet_tail = 1'b1;
         a = random_operand();
         b = random_operand();
         send_pair(a, b, 1'b0, '0, STATUS_NORMAL);
      end
      req_valid <= 1'b0;
      while (pending_quotients.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d operand pairs sent, %0d quotients checked, zero, nan, denormal,",
               operand_pairs_sent, quotients_checked);
      $display("underflow and overflow patterns included, with stalls on both sides");
      if (mismatch_count == 0 && pending_quotients.size() == 0) begin
         $display("single_precision_float_divider verification clean");
      end else begin
         $display("single_precision_float_divider verification failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("single_precision_float_divider verification failed");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
rtl/spfd_pkg.sv
rtl/spfd_cell.sv
rtl/single_precision_float_divider.sv
bench/single_precision_float_divider_test.sv
